@@ src/asfr_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the averaged sample frame responder.
`default_nettype none
package asfr_pkg;

  localparam int unsigned SAMPLES_DEFAULT = 16;
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned SAMPLE_W = 24;
  localparam logic [15:0] DEVICE_ID_RESET = 16'h0001;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef struct packed {
    logic command;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [7:0] request_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic last_byte;
  } out_item_t;

  typedef struct packed {
    logic avg_valid;
    logic [15:0] dev_id;
    logic [SAMPLE_W-1:0] avg;
  } frame_job_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic [7:0] v;
    acc = crc;
    v = data;
    for (int b = 0; b < 8; b++) begin
      if ((v[0] ^ acc[0]) == 1'b1) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
      v = v >> 1;
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

@@ src/asfr_queue.sv @@
// Two-entry queue of frame jobs between the front and back parts.
`default_nettype none
module asfr_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  asfr_pkg::frame_job_t    push_job,
  output logic                    full,
  input  wire                     pop,
  output logic                    head_valid,
  output asfr_pkg::frame_job_t    head_job
);
  import asfr_pkg::*;

  frame_job_t ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ src/asfr_front.sv @@
// Front part: accepts samples and polls, accumulates, divides and queues frame jobs.
`default_nettype none
module asfr_front #(
  parameter int unsigned SAMPLES_PER_AVERAGE = asfr_pkg::SAMPLES_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  asfr_pkg::in_item_t      in_item,
  input  wire                     cfg_wr_en,
  input  wire [15:0]              cfg_wr_data,
  input  wire                     q_full,
  output logic                    q_push,
  output asfr_pkg::frame_job_t    q_job
);
  import asfr_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int unsigned DIV_SH = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  // Rounded-up reciprocal; with this scaling the product gives the exact floor quotient.
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(((64'd1 << DIV_SH) +
                                     64'(SAMPLES_PER_AVERAGE) - 64'd1) /
                                     64'(SAMPLES_PER_AVERAGE));

  logic [15:0]               dev_id_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic [SAMPLE_W-1:0]       avg_r;
  logic                      avg_valid_r;
  logic                      busy_r;
  logic                      div_phase_r;
  logic                      neg_r;
  logic [SUM_W-1:0]          mag_r;
  logic [SAMPLE_W-1:0]       quo_r;
  logic [PROD_W-1:0]         prod;
  logic                      accept;
  logic                      sample_acc;
  logic                      block_end;
  logic [SUM_W-1:0]          sum_mag;

  assign in_stall = busy_r | q_full;
  assign accept = in_valid & ~in_stall;
  assign sample_acc = accept & (in_item.command == CMD_SAMPLE);
  assign block_end = (cnt_r == CNT_W'(SAMPLES_PER_AVERAGE - 1));
  assign q_push = accept & (in_item.command == CMD_POLL) &
                  ({8'h00, in_item.request_byte} == dev_id_r);

  always_comb begin
    q_job.avg_valid = avg_valid_r;
    q_job.dev_id = dev_id_r;
    q_job.avg = avg_r;
  end

  always_comb begin
    sum_nxt = sum_r + SUM_W'(in_item.sample_value);
    sum_mag = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
    prod = PROD_W'(mag_r) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r <= DEVICE_ID_RESET;
      sum_r <= '0;
      cnt_r <= '0;
      avg_r <= '0;
      avg_valid_r <= 1'b0;
      busy_r <= 1'b0;
      div_phase_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_id_r <= cfg_wr_data;
      end
      if (sample_acc) begin
        if (block_end) begin
          sum_r <= '0;
          cnt_r <= '0;
          busy_r <= 1'b1;
          div_phase_r <= 1'b0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (busy_r) begin
        if (div_phase_r) begin
          busy_r <= 1'b0;
          avg_valid_r <= 1'b1;
          avg_r <= neg_r ? (~quo_r + 1'b1) : quo_r;
        end else begin
          div_phase_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc && block_end) begin
      mag_r <= sum_mag;
      neg_r <= sum_nxt[SUM_W-1];
    end
    if (busy_r && !div_phase_r) begin
      quo_r <= prod[DIV_SH +: SAMPLE_W];
    end
  end

endmodule
`default_nettype wire

@@ src/asfr_back.sv @@
// Back part: serializes frame jobs into bytes with a running CRC-8 and an output register.
`default_nettype none
module asfr_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_valid,
  input  asfr_pkg::frame_job_t    q_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output asfr_pkg::out_item_t     out_item
);
  import asfr_pkg::*;

  frame_job_t job_r;
  logic       active_r;
  logic [2:0] idx_r;
  logic [7:0] crc_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic [7:0] byte_sel;
  logic       emit;
  logic       last;

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;
  assign emit = active_r & (~out_valid_r | ~out_stall);
  assign last = (idx_r == 3'(FRAME_LEN - 1));
  assign q_pop = q_valid & (~active_r | (emit & last));

  always_comb begin
    case (idx_r)
      3'd0: byte_sel = job_r.dev_id[7:0];
      3'd1: byte_sel = job_r.dev_id[15:8];
      3'd2: byte_sel = job_r.avg[7:0];
      3'd3: byte_sel = job_r.avg[15:8];
      3'd4: byte_sel = job_r.avg[23:16];
      3'd5: byte_sel = {8{job_r.avg[SAMPLE_W-1]}};
      3'd6: byte_sel = 8'h00;
      3'd7: byte_sel = crc_r;
      default: byte_sel = 8'h00;
    endcase
    if (!job_r.avg_valid) begin
      byte_sel = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (emit && last) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      idx_r <= '0;
      crc_r <= '0;
    end else if (emit) begin
      idx_r <= idx_r + 1'b1;
      crc_r <= crc8_next(crc_r, byte_sel);
    end
    if (emit) begin
      out_item_r.frame_byte <= byte_sel;
      out_item_r.last_byte <= last;
    end
  end

endmodule
`default_nettype wire

@@ src/averaged_sample_frame_responder.sv @@
// Top level of the averaged sample frame responder.
//
// The input channel (in_valid, in_stall, in_item) takes either a signed
// 24-bit sample or a poll byte; a transfer happens when in_valid is high
// and in_stall is low. The output channel (out_valid, out_stall, out_item)
// returns the eight bytes of a reply frame, one byte per transfer, with
// last_byte set on the CRC byte. cfg_wr_en with cfg_wr_data writes the
// device id at any clock edge.
// A matching poll passes through the queue entry, the serializer's job
// register and the output register, and the frame then moves at one byte
// per cycle while the receiver does not stall; a queued frame follows
// without a gap. The sample which completes an average starts a reciprocal
// multiplication that holds in_stall high until the product is registered
// and the average written, so a poll that follows sees the new average.
// Polls queue up to two frames ahead of the serializer, so input transfers
// continue while a frame is still being sent.
// Reset clears the sum, the average and all frames in flight and sets the
// id to one. A stalled receiver holds the current byte; once the queue is
// full, in_stall rises until the serializer frees an entry.
`default_nettype none
module averaged_sample_frame_responder #(
  parameter int unsigned SAMPLES_PER_AVERAGE = asfr_pkg::SAMPLES_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  asfr_pkg::in_item_t      in_item,
  output logic                    out_valid,
  input  wire                     out_stall,
  output asfr_pkg::out_item_t     out_item,
  input  wire                     cfg_wr_en,
  input  wire [15:0]              cfg_wr_data
);
  import asfr_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  frame_job_t push_job;
  frame_job_t head_job;

  asfr_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(push_job)
  );

  asfr_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_job(head_job)
  );

  asfr_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_job(head_job),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

@@ bench/tb_averaged_sample_frame_responder.sv @@
// Self-checking testbench for averaged_sample_frame_responder: random stimulus, predictor, byte checks.
`timescale 1ns / 1ps
module tb_averaged_sample_frame_responder;
  import asfr_pkg::*;

  localparam int unsigned AVG_DEPTH = 16;
  localparam int unsigned FRAME_BYTES = 8;
  localparam logic [7:0] CRC8_POLY_REFL = 8'h8C;
  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int unsigned {
    SMP_RANDOM,
    SMP_MAX,
    SMP_MIN,
    SMP_NEAR_ZERO,
    SMP_NEAR_MAX
  } sample_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;

  logic [15:0] model_id = DEVICE_ID_RESET;
  longint sum_acc = 0;
  int unsigned sum_count = 0;
  logic signed [23:0] avg_latest = '0;
  bit avg_ready = 1'b0;

  in_item_t pending_items[$];
  out_item_t frame_expect[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_frames = 0;
  int unsigned n_bytes = 0;
  int unsigned n_averages = 0;
  int unsigned n_errors = 0;
  int unsigned gen_samples = 0;
  sample_mode_e sample_mode = SMP_RANDOM;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit long_hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  averaged_sample_frame_responder #(
    .SAMPLES_PER_AVERAGE(AVG_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_maxim_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC8_POLY_REFL) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void predict_transfer(input in_item_t it);
    logic [7:0] frame_bytes [FRAME_BYTES];
    logic [31:0] avg32;
    logic [7:0] crc;
    out_item_t r;
    if (it.command == CMD_SAMPLE) begin
      sum_acc += longint'($signed(it.sample_value));
      sum_count++;
      if (sum_count == AVG_DEPTH) begin
        avg_latest = 24'(sum_acc / longint'(AVG_DEPTH));
        avg_ready = 1'b1;
        sum_acc = 0;
        sum_count = 0;
        n_averages++;
      end
    end else if ({8'h00, it.request_byte} == model_id) begin
      for (int k = 0; k < FRAME_BYTES; k++) frame_bytes[k] = 8'h00;
      if (avg_ready) begin
        avg32 = {{8{avg_latest[23]}}, avg_latest};
        frame_bytes[0] = model_id[7:0];
        frame_bytes[1] = model_id[15:8];
        frame_bytes[2] = avg32[7:0];
        frame_bytes[3] = avg32[15:8];
        frame_bytes[4] = avg32[23:16];
        frame_bytes[5] = avg32[31:24];
        crc = 8'h00;
        for (int k = 0; k < FRAME_BYTES - 1; k++) crc = crc8_maxim_update(crc, frame_bytes[k]);
        frame_bytes[FRAME_BYTES-1] = crc;
      end
      for (int k = 0; k < FRAME_BYTES; k++) begin
        r.frame_byte = frame_bytes[k];
        r.last_byte = (k == FRAME_BYTES - 1);
        frame_expect.push_back(r);
      end
      n_frames++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_transfer(in_item);
        n_taken++;
        gap_left = quiet ? 0 : $urandom_range(0, 3);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_bytes++;
        if (frame_expect.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("unexpected frame byte %02h last %0b", out_item.frame_byte,
                     out_item.last_byte);
        end else if (out_item.frame_byte !== frame_expect[0].frame_byte ||
                     out_item.last_byte !== frame_expect[0].last_byte) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                     frame_expect[0].frame_byte, frame_expect[0].last_byte,
                     out_item.frame_byte, out_item.last_byte);
        end
        if (frame_expect.size() > 0) void'(frame_expect.pop_front());
        stall_left = quiet ? 0 : $urandom_range(0, 3);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        if (out_valid) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("averaged_sample_frame_responder regression: fail");
        $finish;
      end
    end
  end

  task automatic push_item(input logic cmd, input logic [23:0] smp, input logic [7:0] req);
    in_item_t it;
    it.command = cmd;
    it.sample_value = smp;
    it.request_byte = req;
    if (cmd == CMD_SAMPLE) gen_samples++;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic add_sample();
    logic [23:0] smp;
    if (gen_samples % AVG_DEPTH == 0) begin
      case ($urandom_range(0, 5))
        2: sample_mode = SMP_MAX;
        3: sample_mode = SMP_MIN;
        4: sample_mode = SMP_NEAR_ZERO;
        5: sample_mode = SMP_NEAR_MAX;
        default: sample_mode = SMP_RANDOM;
      endcase
    end
    case (sample_mode)
      SMP_MAX: smp = SAMPLE_MAX;
      SMP_MIN: smp = SAMPLE_MIN;
      SMP_NEAR_ZERO: smp = 24'($urandom_range(0, 40)) - 24'd20;
      SMP_NEAR_MAX: smp = $urandom_range(0, 1) ? SAMPLE_MAX - 24'($urandom_range(0, 255))
                                               : SAMPLE_MIN + 24'($urandom_range(0, 255));
      default: smp = 24'($urandom);
    endcase
    push_item(CMD_SAMPLE, smp, 8'($urandom));
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        push_item(CMD_POLL, 24'($urandom),
                  ($urandom_range(0, 9) < 7) ? model_id[7:0] : 8'($urandom));
      else
        add_sample();
    end
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || frame_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_id(input logic [15:0] id);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= id;
    model_id = id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] id, input int unsigned count, input logic calm);
    wait_idle();
    write_device_id(id);
    quiet <= calm;
    add_random(count);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Polls before any average exists, then a block whose negative sum
    // must truncate toward zero.
    push_item(CMD_POLL, SAMPLE_MAX, 8'h01);
    push_item(CMD_POLL, SAMPLE_MIN, 8'h00);
    push_item(CMD_POLL, 24'h000000, 8'hFF);
    for (int k = 0; k < AVG_DEPTH; k++)
      push_item(CMD_SAMPLE, (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, (k % 2 == 0) ? 8'hFF : 8'h00);
    push_item(CMD_POLL, 24'hFFFFFF, 8'h01);
    push_item(CMD_POLL, 24'h000000, 8'h01);

    wait_idle();
    write_device_id(16'h0000);
    quiet <= 1'b0;
    long_hold_req <= 1'b1;
    repeat (10) push_item(CMD_POLL, 24'($urandom), 8'h00);
    add_random(70);

    run_phase(16'h00FF, 70, 1'b0);
    run_phase(16'hFFFF, 30, 1'b1);
    run_phase(16'h0100, 30, 1'b0);
    run_phase(16'h0080, 60, 1'b1);
    run_phase(16'($urandom_range(0, 255)), 70, 1'b0);
    run_phase(16'h000C, 40, 1'b0);
    run_phase(16'h0001, 30, 1'b0);
    wait_idle();

    $display("%0d input transfers, %0d reply frames (%0d bytes), %0d completed averages",
             n_taken, n_frames, n_bytes, n_averages);
    $display("ids 1, 0, 255, 65535, 256, 128, 12 and one random byte; one long receiver hold-off");
    if (n_errors == 0 && frame_expect.size() == 0) begin
      $display("averaged_sample_frame_responder regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("averaged_sample_frame_responder regression: fail");
    end
    $finish;
  end

endmodule
